// ===== hdl/sbm_pkg.sv =====
package sbm_pkg;

	localparam int CntW = 27;
	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	typedef enum logic [1:0] {
		OP_ING_ENQ = 2'd0,
		OP_ING_DEQ = 2'd1,
		OP_EGR_ENQ = 2'd2,
		OP_EGR_DEQ = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_BUFFER   = 3'd0,
		REG_RESERVE  = 3'd1,
		REG_RESUME   = 3'd2,
		REG_HEADROOM = 3'd3,
		REG_PORTS    = 3'd4,
		REG_ECN_MIN  = 3'd5,
		REG_ECN_MAX  = 3'd6,
		REG_ECN_PROB = 3'd7
	} reg_t;

	typedef struct packed {
		logic [26:0] buffer_bytes;
		logic [20:0] reserve_bytes;
		logic [20:0] resume_offset_bytes;
		logic [22:0] headroom_bytes;
		logic [5:0]  active_ports;
		logic [26:0] ecn_min_bytes;
		logic [26:0] ecn_max_bytes;
		logic [16:0] ecn_max_prob;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic taken_calc;
		logic eval;
		logic ecn_mul;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_range;
	} sts_t;

endpackage

// ===== hdl/shared_buffer_pfc_ecn_mmu.sv =====
// Buffer manager for switch queues: one start word (operation, port, priority, size,
// random draw) is taken when busy is low, and exactly one result word follows on the
// result ports with done high for one cycle, registered from the commit state; the
// receiver cannot stall. Each word runs through a six-state sequencer doing a read,
// threshold, update, ECN multiply and write-back of one queue entry, so a new word is
// taken only after the last one has been written back and busy is low. Config writes
// are taken at any edge with cfg_we high.
module shared_buffer_pfc_ecn_mmu #(
	parameter int PORTS       = 32,
	parameter int QUEUES      = 8,
	parameter int ALPHA_SHIFT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [26:0] cfg_data,
	input  logic [1:0]  operation,
	input  logic [4:0]  port,
	input  logic [2:0]  priority_req,
	input  logic [15:0] packet_bytes,
	input  logic [15:0] random_draw,
	output logic        done,
	output logic        admitted,
	output logic        send_pause,
	output logic        send_resume,
	output logic        ecn_mark,
	output logic [26:0] shared_total
);
	import sbm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_bytes <= 27'd12582912;
			cfg_q.reserve_bytes <= 21'd4096;
			cfg_q.resume_offset_bytes <= 21'd3072;
			cfg_q.headroom_bytes <= '0;
			cfg_q.active_ports <= 6'd32;
			cfg_q.ecn_min_bytes <= '0;
			cfg_q.ecn_max_bytes <= '0;
			cfg_q.ecn_max_prob <= '0;
		end else if (cfg_we) begin
			unique case (reg_t'(cfg_index))
				REG_BUFFER:   cfg_q.buffer_bytes <= cfg_data;
				REG_RESERVE:  cfg_q.reserve_bytes <= cfg_data[20:0];
				REG_RESUME:   cfg_q.resume_offset_bytes <= cfg_data[20:0];
				REG_HEADROOM: cfg_q.headroom_bytes <= cfg_data[22:0];
				REG_PORTS:    cfg_q.active_ports <= cfg_data[5:0];
				REG_ECN_MIN:  cfg_q.ecn_min_bytes <= cfg_data;
				REG_ECN_MAX:  cfg_q.ecn_max_bytes <= cfg_data;
				REG_ECN_PROB: cfg_q.ecn_max_prob <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	sbm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	sbm_datapath #(.PORTS(PORTS), .QUEUES(QUEUES), .ALPHA_SHIFT(ALPHA_SHIFT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg_q),
		.operation(operation), .port(port), .priority_req(priority_req),
		.packet_bytes(packet_bytes), .random_draw(random_draw), .sts(sts),
		.done(done), .admitted(admitted), .send_pause(send_pause),
		.send_resume(send_resume), .ecn_mark(ecn_mark), .shared_total(shared_total)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> done) else $error("done missing after commit");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy) else $error("busy not raised");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(send_pause && send_resume)) else $error("pause and resume together");
endmodule

// ===== hdl/sbm_ctrl.sv =====
module sbm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sbm_pkg::sts_t sts,
	output logic          busy,
	output sbm_pkg::cmd_t cmd
);
	import sbm_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_TAKEN = 6'b000010,
		S_THR   = 6'b000100,
		S_EVAL  = 6'b001000,
		S_MUL   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_TAKEN;
				end
			end
			S_TAKEN: begin
				cmd.taken_calc = 1'b1;
				state_d = S_THR;
			end
			S_THR: state_d = S_EVAL;
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.ecn_mul = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.commit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic unused_sts;
	assign unused_sts = sts.in_range;
endmodule

// ===== hdl/sbm_datapath.sv =====
module sbm_datapath #(
	parameter int PORTS       = 32,
	parameter int QUEUES      = 8,
	parameter int ALPHA_SHIFT = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sbm_pkg::cmd_t cmd,
	input  sbm_pkg::cfg_t cfg,
	input  logic [1:0]    operation,
	input  logic [4:0]    port,
	input  logic [2:0]    priority_req,
	input  logic [15:0]   packet_bytes,
	input  logic [15:0]   random_draw,
	output sbm_pkg::sts_t sts,
	output logic          done,
	output logic          admitted,
	output logic          send_pause,
	output logic          send_resume,
	output logic          ecn_mark,
	output logic [26:0]   shared_total
);
	import sbm_pkg::*;

	localparam int NQ = PORTS * QUEUES;
	localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;

	logic [CntW-1:0] ing_mem [NQ];
	logic [CntW-1:0] hdr_mem [NQ];
	logic [CntW-1:0] egr_mem [NQ];
	logic [NQ-1:0]   valid_q;
	logic [NQ-1:0]   pause_q;
	logic [CntW-1:0] shared_q;

	logic [1:0]      op_q;
	logic [2:0]      prio_q;
	logic [15:0]     bytes_q;
	logic [15:0]     draw_q;
	logic            inr_q;
	logic [QW-1:0]   qi_q;
	logic [CntW-1:0] ing_q, hdr_q, egr_q;
	logic            val_q;
	logic [34:0]     taken_q;
	logic [34:0]     base_q;
	logic [CntW-1:0] thr_q;
	logic [CntW-1:0] thr2_q;
	logic [CntW-1:0] egr_new_q;
	logic [CntW-1:0] ing_new_q, hdr_new_q, sh_new_q, sp_new_q;
	logic            adm_q, pause_ev_q, resume_ev_q, mark_q;
	logic            big_q, mid_q;
	logic [43:0]     lhs_q;
	logic [CntW-1:0] ovmin_q;
	logic            done_q;

	logic            inr;
	logic [QW+4:0]   qfull;
	assign inr = (32'(port) < PORTS) && (32'(priority_req) < QUEUES);
	assign qfull = (QW+5)'(32'(port) * QUEUES + 32'(priority_req));
	assign sts.in_range = inr_q;

	logic [CntW-1:0] ing_c, hdr_c, egr_c;
	assign ing_c = val_q ? ing_q : '0;
	assign hdr_c = val_q ? hdr_q : '0;
	assign egr_c = val_q ? egr_q : '0;

	function automatic logic [CntW-1:0] sadd(input logic [CntW:0] s);
		return s[CntW] ? CntMax : s[CntW-1:0];
	endfunction

	function automatic logic [CntW-1:0] ssub(input logic [CntW-1:0] a,
		input logic [CntW-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	logic [CntW-1:0] sp, rsv;
	assign rsv = CntW'(cfg.reserve_bytes);
	assign sp = ssub(ing_c, rsv);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			prio_q <= priority_req;
			bytes_q <= packet_bytes;
			draw_q <= random_draw;
			inr_q <= inr;
			qi_q <= qfull[QW-1:0];
		end
		if (cmd.taken_calc) begin
			ing_q <= ing_mem[qi_q];
			hdr_q <= hdr_mem[qi_q];
			egr_q <= egr_mem[qi_q];
			val_q <= valid_q[qi_q];
			taken_q <= 35'(cfg.active_ports * cfg.headroom_bytes)
				+ 35'(cfg.active_ports * cfg.reserve_bytes) + 35'(shared_q);
			base_q <= 35'(cfg.active_ports * cfg.headroom_bytes)
				+ 35'(cfg.active_ports * cfg.reserve_bytes);
		end
	end

	logic [34:0] free_v;
	assign free_v = 35'(cfg.buffer_bytes) - taken_q;
	always_ff @(posedge clk) begin
		if (!cmd.taken_calc && !cmd.eval && !cmd.ecn_mul && !cmd.commit && !cmd.load)
			thr_q <= (taken_q >= 35'(cfg.buffer_bytes)) ? '0
				: CntW'(free_v >> ALPHA_SHIFT);
	end

	logic [CntW:0]   nb, over;
	logic [CntW-1:0] fh, rest, fs, ing_d, hdr_d, sh_d, e_d;
	logic            adm;
	logic [15:0]     ovb;
	always_comb begin
		ing_d = ing_c;
		hdr_d = hdr_c;
		sh_d = shared_q;
		e_d = egr_c;
		adm = 1'b1;
		nb = {1'b0, ing_c} + (CntW+1)'(bytes_q);
		over = nb - (CntW+1)'(rsv);
		ovb = (over < (CntW+1)'(bytes_q)) ? over[15:0] : bytes_q;
		fh = (hdr_c < CntW'(bytes_q)) ? hdr_c : CntW'(bytes_q);
		rest = CntW'(bytes_q) - fh;
		fs = (rest < sp) ? rest : sp;
		if (!inr_q) begin
			adm = (op_q != OP_ING_ENQ);
		end else begin
			case (op_q)
				OP_ING_ENQ: begin
					if (({1'b0, hdr_c} + (CntW+1)'(bytes_q) > (CntW+1)'(cfg.headroom_bytes))
						&& ({1'b0, sp} + (CntW+1)'(bytes_q) > {1'b0, thr_q})) begin
						adm = 1'b0;
					end else begin
						if (nb <= (CntW+1)'(rsv)) begin
							ing_d = sadd({1'b0, ing_c} + (CntW+1)'(bytes_q));
						end else if (over > {1'b0, thr_q}) begin
							hdr_d = sadd({1'b0, hdr_c} + (CntW+1)'(bytes_q));
						end else begin
							ing_d = sadd({1'b0, ing_c} + (CntW+1)'(bytes_q));
							sh_d = sadd({1'b0, shared_q} + (CntW+1)'(ovb));
						end
					end
				end
				OP_ING_DEQ: begin
					hdr_d = hdr_c - fh;
					ing_d = ssub(ing_c, rest);
					sh_d = ssub(shared_q, fs);
				end
				OP_EGR_ENQ: e_d = sadd({1'b0, egr_c} + (CntW+1)'(bytes_q));
				default: e_d = ssub(egr_c, CntW'(bytes_q));
			endcase
		end
	end

	logic [CntW-1:0] sp_d;
	assign sp_d = ssub(ing_d, rsv);

	// threshold after the shared count has moved
	logic [34:0] taken2_v, free2_v;
	assign taken2_v = base_q + 35'(sh_new_q);
	assign free2_v = 35'(cfg.buffer_bytes) - taken2_v;

	logic pf, pev, rev;
	assign pf = valid_q[qi_q] & pause_q[qi_q];
	assign pev = inr_q && (op_q == OP_ING_ENQ) && adm_q && !pf
		&& (hdr_new_q != '0 || sp_new_q >= thr2_q);
	assign rev = inr_q && (op_q == OP_ING_DEQ) && pf && (hdr_new_q == '0)
		&& (sp_new_q == '0 || {1'b0, sp_new_q} + (CntW+1)'(cfg.resume_offset_bytes)
			<= {1'b0, thr2_q});

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			ing_new_q <= ing_d;
			hdr_new_q <= hdr_d;
			sh_new_q <= sh_d;
			sp_new_q <= sp_d;
			egr_new_q <= e_d;
			adm_q <= adm;
			big_q <= e_d > cfg.ecn_max_bytes;
			mid_q <= e_d > cfg.ecn_min_bytes;
			lhs_q <= 44'(draw_q) * 44'(cfg.ecn_max_bytes - cfg.ecn_min_bytes);
			ovmin_q <= e_d - cfg.ecn_min_bytes;
		end
		if (cmd.ecn_mul) begin
			mark_q <= inr_q && (op_q == OP_EGR_DEQ) && (prio_q != 3'd0)
				&& (big_q || (mid_q && lhs_q < 44'(cfg.ecn_max_prob) * 44'(ovmin_q)));
			thr2_q <= (taken2_v >= 35'(cfg.buffer_bytes)) ? '0
				: CntW'(free2_v >> ALPHA_SHIFT);
		end
		if (cmd.commit) begin
			pause_ev_q <= pev;
			resume_ev_q <= rev;
		end
		if (cmd.commit && inr_q) begin
			ing_mem[qi_q] <= ing_new_q;
			hdr_mem[qi_q] <= hdr_new_q;
			egr_mem[qi_q] <= egr_new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pause_q <= '0;
			shared_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit && inr_q) begin
				valid_q[qi_q] <= 1'b1;
				pause_q[qi_q] <= (pf | pev) & ~rev;
				shared_q <= sh_new_q;
			end
		end
	end

	assign done = done_q;
	assign admitted = adm_q;
	assign send_pause = pause_ev_q;
	assign send_resume = resume_ev_q;
	assign ecn_mark = mark_q;
	assign shared_total = shared_q;
endmodule

// ===== tb/shared_buffer_pfc_ecn_mmu_test.sv =====
`timescale 1ns / 1ps

module shared_buffer_pfc_ecn_mmu_test;
	import sbm_pkg::*;

	typedef struct packed {
		op_t         op;
		logic [4:0]  port;
		logic [2:0]  prio;
		logic [15:0] bytes;
		logic [15:0] draw;
	} pkt_t;

	typedef struct packed {
		logic        admitted;
		logic        pause;
		logic        resume;
		logic        mark;
		logic [26:0] shared;
	} verdict_t;

	localparam longint unsigned SatMax = 64'h7FF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_BUFFER;
	logic [26:0] cfg_data = '0;
	logic [1:0]  operation = OP_ING_ENQ;
	logic [4:0]  port = '0;
	logic [2:0]  priority_req = '0;
	logic [15:0] packet_bytes = '0;
	logic [15:0] random_draw = '0;
	logic        done;
	logic        admitted;
	logic        send_pause;
	logic        send_resume;
	logic        ecn_mark;
	logic [26:0] shared_total;

	shared_buffer_pfc_ecn_mmu uut (.*);

	// model configuration and queue state
	longint unsigned m_buf, m_rsv, m_resume, m_hdrm, m_ports, m_emin, m_emax, m_eprob;
	longint unsigned q_ing[256], q_hdrm[256], q_egr[256];
	bit              q_paused[256];
	longint unsigned m_shared;

	pkt_t     pending_words[$];
	verdict_t awaited[$];
	int       errors = 0;
	int       gap = 0;
	bit       idle_on = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("shared_buffer_pfc_ecn_mmu test failed");
		$finish;
	end

	function automatic longint unsigned sat_plus(longint unsigned a, longint unsigned b);
		return (a + b > SatMax) ? SatMax : a + b;
	endfunction

	function automatic longint unsigned sat_minus(longint unsigned a, longint unsigned b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic longint unsigned pfc_limit();
		longint unsigned taken;
		taken = m_ports * m_hdrm + m_ports * m_rsv + m_shared;
		if (taken >= m_buf) return 0;
		return (m_buf - taken) >> 3;
	endfunction

	function automatic verdict_t account(pkt_t w);
		verdict_t        v;
		int              q;
		longint unsigned b, nb, over, from_h, rest, sp, from_s, e;
		v = '{admitted: 1'b1, pause: 1'b0, resume: 1'b0, mark: 1'b0, shared: '0};
		q = w.port * 8 + w.prio;
		b = w.bytes;
		case (w.op)
			OP_ING_ENQ: begin
				if (b + q_hdrm[q] > m_hdrm &&
						b + sat_minus(q_ing[q], m_rsv) > pfc_limit()) begin
					v.admitted = 1'b0;
				end else begin
					nb = q_ing[q] + b;
					if (nb <= m_rsv) begin
						q_ing[q] = sat_plus(q_ing[q], b);
					end else if (nb - m_rsv > pfc_limit()) begin
						q_hdrm[q] = sat_plus(q_hdrm[q], b);
					end else begin
						over = nb - m_rsv;
						q_ing[q] = sat_plus(q_ing[q], b);
						m_shared = sat_plus(m_shared, b < over ? b : over);
					end
					if (!q_paused[q] &&
							(q_hdrm[q] > 0 || sat_minus(q_ing[q], m_rsv) >= pfc_limit())) begin
						q_paused[q] = 1'b1;
						v.pause = 1'b1;
					end
				end
			end
			OP_ING_DEQ: begin
				from_h = q_hdrm[q] < b ? q_hdrm[q] : b;
				rest = b - from_h;
				sp = sat_minus(q_ing[q], m_rsv);
				from_s = rest < sp ? rest : sp;
				q_hdrm[q] = q_hdrm[q] - from_h;
				q_ing[q] = sat_minus(q_ing[q], rest);
				m_shared = sat_minus(m_shared, from_s);
				if (q_paused[q] && q_hdrm[q] == 0) begin
					sp = sat_minus(q_ing[q], m_rsv);
					if (sp == 0 || sp + m_resume <= pfc_limit()) begin
						q_paused[q] = 1'b0;
						v.resume = 1'b1;
					end
				end
			end
			OP_EGR_ENQ: q_egr[q] = sat_plus(q_egr[q], b);
			default: begin
				q_egr[q] = sat_minus(q_egr[q], b);
				e = q_egr[q];
				if (w.prio != 0) begin
					if (e > m_emax) v.mark = 1'b1;
					else if (e > m_emin &&
							longint'(w.draw) * (m_emax - m_emin) < m_eprob * (e - m_emin))
						v.mark = 1'b1;
				end
			end
		endcase
		v.shared = m_shared[26:0];
		return v;
	endfunction

	// driver
	always @(posedge clk) begin
		pkt_t w;
		bit   next_start;
		if (arst_n) begin
			if (start && !busy) begin
				w = pending_words.pop_front();
				awaited.push_back(account(w));
				gap = idle_on ? $urandom_range(0, 12) : 0;
			end
			next_start = 1'b0;
			if (gap > 0) begin
				gap--;
			end else if (pending_words.size() > 0) begin
				w = pending_words[0];
				operation <= w.op;
				port <= w.port;
				priority_req <= w.prio;
				packet_bytes <= w.bytes;
				random_draw <= w.draw;
				next_start = 1'b1;
			end
			start <= next_start;
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && done) begin
			got = '{admitted, send_pause, send_resume, ecn_mark, shared_total};
			if (awaited.size() == 0) begin
				$display("%t unexpected word: got %p", $realtime, got);
				errors++;
			end else begin
				want = awaited.pop_front();
				if (got !== want) begin
					$display("%t mismatch: expected %p actual %p", $realtime, want, got);
					errors++;
				end
			end
		end
	end

	function automatic pkt_t mk(op_t op, int p, int pr, int b, int d);
		pkt_t w;
		w.op = op;
		w.port = 5'(p);
		w.prio = 3'(pr);
		w.bytes = 16'(b);
		w.draw = 16'(d);
		return w;
	endfunction

	function automatic pkt_t rand_word();
		int   r, b;
		op_t  op;
		r = $urandom_range(0, 99);
		op = r < 35 ? OP_ING_ENQ : r < 65 ? OP_ING_DEQ : r < 80 ? OP_EGR_ENQ : OP_EGR_DEQ;
		r = $urandom_range(0, 99);
		b = r < 70 ? $urandom_range(0, 3000) : r < 95 ? $urandom_range(0, 20000)
			: $urandom_range(0, 65535);
		return mk(op, $urandom_range(0, 4) < 4 ? $urandom_range(0, 3) : $urandom_range(0, 31),
			$urandom_range(0, 7), b, $urandom_range(0, 65535));
	endfunction

	task automatic set_reg(reg_t idx, longint unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[26:0];
		case (idx)
			REG_BUFFER:   m_buf = v & 64'h7FF_FFFF;
			REG_RESERVE:  m_rsv = v & 64'h1F_FFFF;
			REG_RESUME:   m_resume = v & 64'h1F_FFFF;
			REG_HEADROOM: m_hdrm = v & 64'h7F_FFFF;
			REG_PORTS:    m_ports = v & 64'h3F;
			REG_ECN_MIN:  m_emin = v & 64'h7FF_FFFF;
			REG_ECN_MAX:  m_emax = v & 64'h7FF_FFFF;
			default:      m_eprob = v & 64'h1_FFFF;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(longint unsigned bb, rs, ro, hr, ap, emin, emax, ep);
		set_reg(REG_BUFFER, bb);
		set_reg(REG_RESERVE, rs);
		set_reg(REG_RESUME, ro);
		set_reg(REG_HEADROOM, hr);
		set_reg(REG_PORTS, ap);
		set_reg(REG_ECN_MIN, emin);
		set_reg(REG_ECN_MAX, emax);
		set_reg(REG_ECN_PROB, ep);
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || awaited.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_random(int n);
		repeat (n) pending_words.push_back(rand_word());
		drain();
	endtask

	initial begin
		m_buf = 12582912; m_rsv = 4096; m_resume = 3072; m_hdrm = 0;
		m_ports = 32; m_emin = 0; m_emax = 0; m_eprob = 0; m_shared = 0;
		for (int i = 0; i < 256; i++) begin
			q_ing[i] = 0; q_hdrm[i] = 0; q_egr[i] = 0; q_paused[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults out of reset
		pending_words.push_back(mk(OP_ING_ENQ, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_ING_ENQ, 31, 7, 65535, 65535));
		pending_words.push_back(mk(OP_ING_DEQ, 31, 7, 65535, 0));
		pending_words.push_back(mk(OP_ING_DEQ, 5, 3, 100, 0));
		pending_words.push_back(mk(OP_EGR_ENQ, 2, 0, 65535, 0));
		pending_words.push_back(mk(OP_EGR_DEQ, 2, 0, 10, 0));
		pending_words.push_back(mk(OP_EGR_ENQ, 2, 5, 65535, 0));
		pending_words.push_back(mk(OP_EGR_DEQ, 2, 5, 10, 65535));
		pending_words.push_back(mk(OP_EGR_DEQ, 2, 5, 65535, 0));
		drain();
		run_random(200);

		// tight buffer: pause, headroom, resume and linear marking
		set_all(150000, 2048, 1024, 16384, 4, 1000, 100000, 65536);
		for (int i = 0; i < 6; i++) pending_words.push_back(mk(OP_ING_ENQ, 1, 3, 9000, 0));
		pending_words.push_back(mk(OP_ING_ENQ, 1, 3, 65535, 0));
		for (int i = 0; i < 6; i++) pending_words.push_back(mk(OP_ING_DEQ, 1, 3, 12000, 0));
		pending_words.push_back(mk(OP_EGR_ENQ, 1, 3, 50000, 0));
		pending_words.push_back(mk(OP_EGR_DEQ, 1, 3, 0, 65535));
		pending_words.push_back(mk(OP_EGR_DEQ, 1, 3, 0, 0));
		pending_words.push_back(mk(OP_EGR_DEQ, 1, 3, 49500, 0));
		drain();
		run_random(400);

		idle_on = 1'b0;
		set_all(67108864, 1048576, 1048576, 4194304, 32, 0, 67108864, 32768);
		run_random(150);

		set_all(0, 0, 0, 0, 0, 0, 0, 0);
		run_random(150);

		idle_on = 1'b1;
		set_all(400000, 512, 0, 0, 1, 5000, 5000, 65536);
		run_random(200);

		for (int k = 0; k < 4; k++) begin
			idle_on = k[0];
			set_all($urandom_range(20000, 600000), $urandom_range(0, 8192),
				$urandom_range(0, 8192), $urandom_range(0, 30000), $urandom_range(0, 32),
				$urandom_range(0, 20000), $urandom_range(20000, 200000),
				$urandom_range(0, 65536));
			run_random(100);
		end

		if (errors == 0) begin
			$display("shared_buffer_pfc_ecn_mmu test passed");
		end else begin
			$display("shared_buffer_pfc_ecn_mmu test failed");
		end
		$finish;
	end

endmodule
